>>> sv/first_fit_heap_allocator_macros.svh
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_macros
// Assertion shorthands shared by the checker.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// same-cycle implication, quiet during reset
`define FFHA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// next-cycle implication, quiet during reset
`define FFHA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

>>> sv/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int HEAP_BYTES  = 65536;
    localparam int HDR_WORDS   = (12 + 3) / 4;
    localparam int HDR_BYTES   = HDR_WORDS * 4;
    localparam int SPLIT_SLACK = 16;
    localparam int WORDS       = HEAP_BYTES / 4;
    localparam int IDX_W       = $clog2(WORDS);
    localparam int LEN_W       = 17;
    localparam int SZ_W        = LEN_W + 1;
    localparam int MEM_W       = IDX_W + 1 + LEN_W;
    localparam int CFG_IDX_W   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LENGTH = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OOM      = 2'd1,
        ST_NULL     = 2'd2,
        ST_BAD_FREE = 2'd3
    } t_status;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [LEN_W-1:0] alloc_size;
        logic [31:0]      free_addr;
    } t_req;

    typedef struct packed {
        logic [31:0]      alloc_addr;
        t_status          status;
        logic [LEN_W-1:0] free_bytes;
    } t_res;

    typedef struct packed {
        logic    cfg_we;
        logic    init;
        logic    start;
        logic    chk;
        logic    rd;
        logic    a_fit;
        logic    a_adv;
        logic    a_take;
        logic    f_load;
        logic    f_merge;
        logic    f_adv;
        logic    f_end;
        logic    fin;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic fit;
        logic q_next_zero;
        logic addr_null;
        logic addr_bad;
        logic have_cur;
        logic merge;
        logic found;
    } t_stat;

endpackage

>>> sv/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer: init, first-fit walk, free walk with merging.
// ----------------------------------------------------------------------------
module ffha_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic                           i_req_type,
    input  logic                           i_cfg_valid,
    input  logic [ffha_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  ffha_pkg::t_stat                i_stat,
    output ffha_pkg::t_cmd                 o_cmd,
    output logic                           busy,
    output logic                           o_cfg_ready,
    output logic                           o_done
);
    import ffha_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_CHK, S_A_RD, S_A_EV, S_A_TAKE, S_F_RD, S_F_EV, S_F_END
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign o_done      = r_done;

    always_comb begin
        o_cmd        = '0;
        o_cmd.status = ST_OK;
        n_state      = r_state;
        n_done       = 1'b0;
        o_cmd.cfg_we = i_cfg_valid && o_cfg_ready;
        unique case (r_state)
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.start = 1'b1;
                    n_state     = (i_req_type == REQ_FREE) ? S_CHK : S_A_RD;
                end else if (o_cmd.cfg_we &&
                             (i_cfg_index == CFG_HEAP_BASE ||
                              i_cfg_index == CFG_HEAP_LENGTH)) begin
                    n_state = S_INIT;
                end
            end
            S_A_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_A_EV;
            end
            S_A_EV: begin
                if (i_stat.fit) begin
                    o_cmd.a_fit = 1'b1;
                    n_state     = S_A_TAKE;
                end else if (i_stat.q_next_zero) begin
                    o_cmd.fin    = 1'b1;
                    o_cmd.status = ST_OOM;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.a_adv = 1'b1;
                    n_state     = S_A_RD;
                end
            end
            S_A_TAKE: begin
                o_cmd.a_take = 1'b1;
                o_cmd.fin    = 1'b1;
                n_done       = 1'b1;
                n_state      = S_IDLE;
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                if (i_stat.addr_null) begin
                    o_cmd.fin    = 1'b1;
                    o_cmd.status = ST_NULL;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end else if (i_stat.addr_bad) begin
                    o_cmd.fin    = 1'b1;
                    o_cmd.status = ST_BAD_FREE;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_F_RD;
                end
            end
            S_F_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_F_EV;
            end
            S_F_EV: begin
                priority if (!i_stat.have_cur) o_cmd.f_load  = 1'b1;
                else if (i_stat.merge)         o_cmd.f_merge = 1'b1;
                else                           o_cmd.f_adv   = 1'b1;
                n_state = i_stat.q_next_zero ? S_F_END : S_F_RD;
            end
            S_F_END: begin
                o_cmd.f_end  = 1'b1;
                o_cmd.fin    = 1'b1;
                o_cmd.status = i_stat.found ? ST_OK : ST_BAD_FREE;
                n_done       = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

endmodule

>>> sv/ffha_dp.sv
// ----------------------------------------------------------------------------
// ffha_dp
// Header memory, walk registers, free byte count and result registers.
// ----------------------------------------------------------------------------
module ffha_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ffha_pkg::t_cmd                 i_cmd,
    input  ffha_pkg::t_req                 i_req,
    input  logic [ffha_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    output ffha_pkg::t_stat                o_stat,
    output ffha_pkg::t_res                 o_res
);
    import ffha_pkg::*;

    // header word: {next, free, size}
    logic [MEM_W-1:0] r_mem [WORDS];
    logic [MEM_W-1:0] r_q;
    logic [IDX_W-1:0] r_q_idx;

    logic [31:0]      r_base;
    logic [LEN_W-1:0] r_len;
    t_req             r_req;
    logic [SZ_W-1:0]  r_sz;
    logic [IDX_W-1:0] r_rd_idx;
    logic [IDX_W-1:0] r_tgt;
    logic             r_split;
    logic [IDX_W-1:0] r_s;

    logic [IDX_W-1:0] r_cur_idx;
    logic [LEN_W-1:0] r_cur_size;
    logic [IDX_W-1:0] r_cur_next;
    logic             r_cur_free;
    logic             r_dirty;
    logic             r_have_cur;
    logic             r_found;

    logic [LEN_W-1:0] r_free_total;
    logic [31:0]      r_alloc_addr;
    t_status          r_status;

    logic [LEN_W-1:0] q_size;
    logic             q_free;
    logic [IDX_W-1:0] q_next;
    logic             q_is_tgt;
    logic             q_eff_free;
    logic             q_newly;
    logic             split;
    logic [IDX_W-1:0] s_idx;
    logic [SZ_W:0]    split_rest;
    logic [31:0]      off;
    logic [31:0]      off2;
    logic [LEN_W-1:0] cfg_len;
    logic [LEN_W-1:0] cfg_len_m;
    logic             we;
    logic [IDX_W-1:0] wa;
    logic [MEM_W-1:0] wd;

    assign q_size     = r_q[LEN_W-1:0];
    assign q_free     = r_q[LEN_W];
    assign q_next     = r_q[MEM_W-1 -: IDX_W];
    assign q_is_tgt   = (r_q_idx == r_tgt);
    assign q_eff_free = q_free || q_is_tgt;
    assign q_newly    = q_is_tgt && !q_free;

    assign split      = ({2'b00, q_size} >=
                         ({1'b0, r_sz} + (SZ_W+1)'(HDR_BYTES + SPLIT_SLACK)));
    assign s_idx      = r_q_idx + IDX_W'(HDR_WORDS) + r_sz[IDX_W+1:2];
    assign split_rest = {2'b00, q_size} - {1'b0, r_sz} - (SZ_W+1)'(HDR_BYTES);

    // free address -> header index
    assign off  = r_req.free_addr - r_base;
    assign off2 = off - 32'(HDR_BYTES);

    always_comb begin
        o_stat.fit         = q_free && ({1'b0, q_size} >= r_sz);
        o_stat.q_next_zero = (q_next == '0);
        o_stat.addr_null   = (r_req.free_addr == '0);
        o_stat.addr_bad    = (off < 32'(HDR_BYTES)) || (off2[1:0] != 2'b00) ||
                             (off2 >= {{(32-LEN_W){1'b0}}, r_len});
        o_stat.have_cur    = r_have_cur;
        o_stat.merge       = r_cur_free && q_eff_free;
        o_stat.found       = r_found;
    end

    // clamp the length register to whole words, one header .. heap size
    always_comb begin
        cfg_len_m = i_cfg_data[LEN_W-1:0] & ~LEN_W'(3);
        if (cfg_len_m > LEN_W'(HEAP_BYTES))      cfg_len = LEN_W'(HEAP_BYTES);
        else if (cfg_len_m < LEN_W'(HDR_BYTES))  cfg_len = LEN_W'(HDR_BYTES);
        else                                     cfg_len = cfg_len_m;
    end

    // single write port
    always_comb begin
        we = 1'b0;
        wa = '0;
        wd = '0;
        priority if (i_cmd.init) begin
            we = 1'b1;
            wd = {IDX_W'(0), 1'b1, r_len - LEN_W'(HDR_BYTES)};
        end else if (i_cmd.a_fit && split) begin
            we = 1'b1;
            wa = s_idx;
            wd = {q_next, 1'b1, split_rest[LEN_W-1:0]};
        end else if (i_cmd.a_take) begin
            we = 1'b1;
            wa = r_q_idx;
            wd = r_split ? {r_s, 1'b0, r_sz[LEN_W-1:0]} : {q_next, 1'b0, q_size};
        end else if ((i_cmd.f_adv || i_cmd.f_end) && r_dirty) begin
            we = 1'b1;
            wa = r_cur_idx;
            wd = {r_cur_next, r_cur_free, r_cur_size};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        if (i_cmd.rd) r_q <= r_mem[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= '0;
            r_len      <= LEN_W'(HEAP_BYTES);
            r_have_cur <= 1'b0;
            r_found    <= 1'b0;
            r_dirty    <= 1'b0;
        end else begin
            if (i_cmd.cfg_we) begin
                if (i_cfg_index == CFG_HEAP_BASE)   r_base <= i_cfg_data & ~32'd3;
                if (i_cfg_index == CFG_HEAP_LENGTH) r_len  <= cfg_len;
            end
            if (i_cmd.init) r_free_total <= r_len - LEN_W'(HDR_BYTES);
            if (i_cmd.start) begin
                r_req        <= i_req;
                r_sz         <= ({1'b0, i_req.alloc_size} + SZ_W'(3)) & ~SZ_W'(3);
                r_rd_idx     <= '0;
                r_have_cur   <= 1'b0;
                r_found      <= 1'b0;
                r_dirty      <= 1'b0;
                r_alloc_addr <= '0;
            end
            if (i_cmd.chk) r_tgt <= off2[IDX_W+1:2];
            if (i_cmd.rd)  r_q_idx <= r_rd_idx;
            if (i_cmd.a_adv) r_rd_idx <= q_next;
            if (i_cmd.a_fit) begin
                r_split <= split;
                r_s     <= s_idx;
            end
            if (i_cmd.a_take) begin
                r_alloc_addr <= r_base + {{(30-IDX_W){1'b0}}, r_q_idx, 2'b00}
                                + 32'(HDR_BYTES);
                r_free_total <= r_split
                    ? r_free_total - r_sz[LEN_W-1:0] - LEN_W'(HDR_BYTES)
                    : r_free_total - q_size;
            end
            if (i_cmd.f_load || i_cmd.f_adv) begin
                r_cur_idx  <= r_q_idx;
                r_cur_size <= q_size;
                r_cur_next <= q_next;
                r_cur_free <= q_eff_free;
                r_dirty    <= q_newly;
                r_have_cur <= 1'b1;
                r_found    <= r_found || q_is_tgt;
                r_rd_idx   <= q_next;
                if (q_newly) r_free_total <= r_free_total + q_size;
            end
            if (i_cmd.f_merge) begin
                r_cur_size   <= r_cur_size + LEN_W'(HDR_BYTES) + q_size;
                r_cur_next   <= q_next;
                r_dirty      <= 1'b1;
                r_found      <= r_found || q_is_tgt;
                r_rd_idx     <= q_next;
                r_free_total <= r_free_total + LEN_W'(HDR_BYTES) +
                                (q_newly ? q_size : LEN_W'(0));
            end
            if (i_cmd.fin) r_status <= i_cmd.status;
        end
    end

    assign o_res.alloc_addr = r_alloc_addr;
    assign o_res.status     = r_status;
    assign o_res.free_bytes = r_free_total;

endmodule

>>> sv/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit free-list heap allocator with coalescing of free blocks.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive i_req and raise start; the request is taken on a
//   clock edge where start is high and busy is low. req_type 0 allocates
//   alloc_size bytes (rounded up to 4), 1 frees the payload at free_addr.
//   Result channel: o_done pulses for one cycle with o_res valid; there is no
//   back-pressure, so the result must be sampled in that cycle.
//   Config channel: i_cfg_valid/o_cfg_ready write heap_base (index 0) or
//   heap_length (index 1); either write rebuilds the heap as one free block.
//   Other indexes are taken and ignored.
// Sequence:
//   Allocate: each block header visited is read from memory and then
//   compared, then the taken block is written; done follows in the next cycle.
//   Free: an address check, then a read and an evaluate (load, merge or
//   advance) per block of the whole chain, then a write-back.
// Reset: synchronous, active low; base 0, length 64 KiB, then an init state
//   with busy high before the first request is taken.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  ffha_pkg::t_req                 i_req,
    output logic                           busy,
    output logic                           o_done,
    output ffha_pkg::t_res                 o_res,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ffha_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import ffha_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    ffha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req_type  (i_req.req_type),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .busy        (busy),
        .o_cfg_ready (o_cfg_ready),
        .o_done      (o_done)
    );

    // header memory and arithmetic
    ffha_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_req),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (stat),
        .o_res       (o_res)
    );

endmodule

>>> sv/ffha_checker.sv
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_macros.svh"

module ffha_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input ffha_pkg::t_req                 i_req,
    input logic                           busy,
    input logic                           o_done,
    input ffha_pkg::t_res                 o_res,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic [ffha_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [31:0]                    i_cfg_data
);
    import ffha_pkg::*;

    // a taken request makes the block busy
    `FFHA_ASSERT_NXT(a_start_busy, start && !busy, busy)
    // the result pulse comes as the block frees up
    `FFHA_ASSERT_IMP(a_done_idle, o_done, !busy)
    // a failed allocate hands out no address
    `FFHA_ASSERT_IMP(a_oom_null, o_done && o_res.status == ST_OOM, o_res.alloc_addr == '0)
    // a heap register write rebuilds the heap
    `FFHA_ASSERT_NXT(a_cfg_init,
        i_cfg_valid && o_cfg_ready && (i_cfg_index == CFG_HEAP_BASE ||
        i_cfg_index == CFG_HEAP_LENGTH), busy)

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);
